>>> design/double_hash_set_engine_macros.svh
// assertion macros for the hash set engine
`ifndef DOUBLE_HASH_SET_ENGINE_MACROS_SVH
`define DOUBLE_HASH_SET_ENGINE_MACROS_SVH

// checked outside reset
`define DHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked in reset too
`define DHS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dhs_pkg.sv
package dhs_pkg;

	localparam int TABLE_SIZE_DEF = 1021;
	localparam int KEY_WIDTH_DEF  = 32;
	localparam int LOAD_NUM       = 6;
	localparam int LOAD_DEN       = 10;
	localparam int LIMIT_W        = 10;
	localparam int LIVE_W         = 10;

	localparam logic [1:0] TAG_EMPTY   = 2'd0;
	localparam logic [1:0] TAG_DELETED = 2'd1;
	localparam logic [1:0] TAG_FULL    = 2'd2;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key;
	} in_req_t;

	typedef struct packed {
		logic              found;
		logic              changed;
		logic              status;
		logic [LIVE_W-1:0] live_count;
	} out_rsp_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_RD,
		B_CHK,
		B_CLR,
		B_DONE
	} back_state_t;

endpackage

>>> design/dhs_ram.sv
module dhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/dhs_queue.sv
module dhs_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/dhs_front.sv
module dhs_front #(
	parameter int TABLE_SIZE = dhs_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = dhs_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dhs_pkg::back_stat_t           stat,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dhs_pkg::in_req_t              in_data,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [1:0]                    push_req,
	output logic [KEY_WIDTH-1:0]          push_key,
	output logic [$clog2(TABLE_SIZE)-1:0] push_idx,
	output logic [$clog2(TABLE_SIZE)-1:0] push_stride
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int KP = ((KEY_WIDTH + 15) / 16) * 16;
	localparam int NG = KP / 16;
	localparam int GW = $clog2(NG + 1);
	localparam int VW = IW + 16;
	localparam int MW = VW + 2;
	localparam int SH = VW + IW;
	localparam logic [IW:0] M1 = (IW+1)'(TABLE_SIZE);
	localparam logic [IW:0] M2 = (IW+1)'(TABLE_SIZE - 2);
	localparam logic [MW-1:0] RC1 = MW'(((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) /
		64'(TABLE_SIZE));
	localparam logic [MW-1:0] RC2 = MW'(((64'd1 << SH) + 64'(TABLE_SIZE - 2) - 64'd1) /
		64'(TABLE_SIZE - 2));

	dhs_pkg::front_state_t state_q, state_d;
	logic [1:0]           req_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KP-1:0]        sh_q;
	logic [IW-1:0]        r1_q, r2_q, r1_d, r2_d;
	logic [GW-1:0]        grp_q;
	logic                 acc;
	logic [VW-1:0]        v1, v2, qm1, qm2;
	logic [VW+MW-1:0]     p1, p2;
	logic [15:0]          q1_q, q2_q;
	logic                 ph_q;

	assign in_ready    = (state_q == dhs_pkg::F_IDLE) && !stat.init_busy;
	assign acc         = in_valid && in_ready;
	assign push_valid  = (state_q == dhs_pkg::F_PUSH);
	assign push_req    = req_q;
	assign push_key    = key_q;
	assign push_idx    = r1_q;
	assign push_stride = r2_q + IW'(1);

	// sixteen key bits per step, most significant first: quotient by
	// reciprocal in the first phase, remainder in the second
	assign v1   = {r1_q, sh_q[KP-1 -: 16]};
	assign v2   = {r2_q, sh_q[KP-1 -: 16]};
	assign p1   = {{MW{1'b0}}, v1} * {{VW{1'b0}}, RC1};
	assign p2   = {{MW{1'b0}}, v2} * {{VW{1'b0}}, RC2};
	assign qm1  = VW'(q1_q) * VW'(M1);
	assign qm2  = VW'(q2_q) * VW'(M2);
	assign r1_d = IW'(v1 - qm1);
	assign r2_d = IW'(v2 - qm2);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dhs_pkg::F_IDLE: begin
				if (acc) begin
					state_d = (in_data.req_type == dhs_pkg::REQ_CLEAR) ?
						dhs_pkg::F_PUSH : dhs_pkg::F_HASH;
				end
			end
			dhs_pkg::F_HASH: begin
				if (ph_q && grp_q == GW'(NG - 1)) begin
					state_d = dhs_pkg::F_PUSH;
				end
			end
			dhs_pkg::F_PUSH: begin
				if (push_ready) begin
					state_d = dhs_pkg::F_IDLE;
				end
			end
			default: state_d = dhs_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhs_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= in_data.req_type;
			key_q <= KEY_WIDTH'(in_data.key);
			sh_q  <= KP'(KEY_WIDTH'(in_data.key));
			r1_q  <= '0;
			r2_q  <= '0;
			grp_q <= '0;
			ph_q  <= 1'b0;
		end else if (state_q == dhs_pkg::F_HASH) begin
			if (!ph_q) begin
				q1_q <= p1[SH+15:SH];
				q2_q <= p2[SH+15:SH];
			end else begin
				r1_q  <= r1_d;
				r2_q  <= r2_d;
				sh_q  <= sh_q << 16;
				grp_q <= grp_q + GW'(1);
			end
			ph_q <= !ph_q;
		end
	end

endmodule

>>> design/dhs_back.sv
module dhs_back #(
	parameter int TABLE_SIZE = dhs_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = dhs_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dhs_pkg::LIMIT_W-1:0]   load_limit,
	output dhs_pkg::back_stat_t           stat,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  logic [1:0]                    pop_req,
	input  logic [KEY_WIDTH-1:0]          pop_key,
	input  logic [$clog2(TABLE_SIZE)-1:0] pop_idx,
	input  logic [$clog2(TABLE_SIZE)-1:0] pop_stride,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dhs_pkg::out_rsp_t             out_data
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int LW = (CW + 1 > dhs_pkg::LIMIT_W) ? CW + 1 : dhs_pkg::LIMIT_W;

	dhs_pkg::back_state_t state_q, state_d;
	logic [1:0]           req_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [IW-1:0]        idx_q, stride_q, tomb_q, slot_q, cnt_q;
	logic [CW-1:0]        n_q;
	logic                 tomb_v_q, empty_v_q, present_q, clr_chg_q;
	logic [CW-1:0]        used_q, tombs_q, used_n, tombs_n;
	logic [IW:0]          idx_sum;
	logic [IW-1:0]        idx_nx;

	logic                 tag_we, key_we;
	logic [IW-1:0]        waddr;
	logic [1:0]           tag_wd, tag_rd;
	logic [KEY_WIDTH-1:0] key_rd;

	logic                 out_free, done_go, last_cnt;
	logic                 found_d, changed_d, status_d;

	dhs_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wd),
		.raddr(idx_q), .rdata(tag_rd)
	);

	dhs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_SIZE)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(waddr), .wdata(key_q),
		.raddr(idx_q), .rdata(key_rd)
	);

	assign stat.init_busy = (state_q == dhs_pkg::B_INIT);
	assign pop_ready      = (state_q == dhs_pkg::B_IDLE);
	assign out_free       = !out_valid || out_ready;
	assign done_go        = (state_q == dhs_pkg::B_DONE) && out_free;
	assign last_cnt       = (cnt_q == IW'(TABLE_SIZE - 1));
	assign idx_sum        = {1'b0, idx_q} + {1'b0, stride_q};
	assign idx_nx         = (idx_sum >= (IW+1)'(TABLE_SIZE)) ?
		IW'(idx_sum - (IW+1)'(TABLE_SIZE)) : idx_sum[IW-1:0];

	// sweep writes in init and clear, and commit of one request: writes, counts and result
	always_comb begin
		tag_we    = 1'b0;
		key_we    = 1'b0;
		waddr     = slot_q;
		tag_wd    = dhs_pkg::TAG_EMPTY;
		used_n    = used_q;
		tombs_n   = tombs_q;
		found_d   = 1'b0;
		changed_d = 1'b0;
		status_d  = 1'b0;
		if (state_q == dhs_pkg::B_INIT || state_q == dhs_pkg::B_CLR) begin
			tag_we = 1'b1;
			waddr  = cnt_q;
			if (state_q == dhs_pkg::B_CLR && last_cnt) begin
				used_n  = '0;
				tombs_n = '0;
			end
		end else if (state_q == dhs_pkg::B_DONE) begin
			case (req_q)
				dhs_pkg::REQ_CLEAR: begin
					changed_d = clr_chg_q;
				end
				dhs_pkg::REQ_INSERT: begin
					found_d = present_q;
					if (!present_q) begin
						if (tomb_v_q) begin
							tag_we    = done_go;
							key_we    = done_go;
							waddr     = tomb_q;
							tag_wd    = dhs_pkg::TAG_FULL;
							tombs_n   = tombs_q - CW'(1);
							changed_d = 1'b1;
						end else if (!empty_v_q ||
							(LW'(used_q) + LW'(1) > LW'(load_limit))) begin
							status_d = 1'b1;
						end else begin
							tag_we    = done_go;
							key_we    = done_go;
							tag_wd    = dhs_pkg::TAG_FULL;
							used_n    = used_q + CW'(1);
							changed_d = 1'b1;
						end
					end
				end
				dhs_pkg::REQ_REMOVE: begin
					found_d = present_q;
					if (present_q) begin
						tag_we    = done_go;
						tag_wd    = dhs_pkg::TAG_DELETED;
						tombs_n   = tombs_q + CW'(1);
						changed_d = 1'b1;
					end
				end
				default: begin
					found_d = present_q;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dhs_pkg::B_INIT: begin
				if (last_cnt) begin
					state_d = dhs_pkg::B_IDLE;
				end
			end
			dhs_pkg::B_IDLE: begin
				if (pop_valid) begin
					if (pop_req == dhs_pkg::REQ_CLEAR) begin
						state_d = (used_q != tombs_q) ? dhs_pkg::B_CLR : dhs_pkg::B_DONE;
					end else begin
						state_d = dhs_pkg::B_RD;
					end
				end
			end
			dhs_pkg::B_RD: state_d = dhs_pkg::B_CHK;
			dhs_pkg::B_CHK: begin
				if (tag_rd == dhs_pkg::TAG_EMPTY ||
					(tag_rd == dhs_pkg::TAG_FULL && key_rd == key_q) ||
					n_q == CW'(TABLE_SIZE - 1)) begin
					state_d = dhs_pkg::B_DONE;
				end else begin
					state_d = dhs_pkg::B_RD;
				end
			end
			dhs_pkg::B_CLR: begin
				if (last_cnt) begin
					state_d = dhs_pkg::B_DONE;
				end
			end
			dhs_pkg::B_DONE: begin
				if (out_free) begin
					state_d = dhs_pkg::B_IDLE;
				end
			end
			default: state_d = dhs_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dhs_pkg::B_INIT;
			cnt_q     <= '0;
			used_q    <= '0;
			tombs_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dhs_pkg::B_INIT || state_q == dhs_pkg::B_CLR) begin
				cnt_q <= last_cnt ? '0 : cnt_q + IW'(1);
			end
			if (state_q == dhs_pkg::B_CLR || done_go) begin
				used_q  <= used_n;
				tombs_q <= tombs_n;
			end
			if (done_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			req_q     <= pop_req;
			key_q     <= pop_key;
			idx_q     <= pop_idx;
			stride_q  <= pop_stride;
			n_q       <= '0;
			tomb_v_q  <= 1'b0;
			empty_v_q <= 1'b0;
			present_q <= 1'b0;
			clr_chg_q <= (used_q != tombs_q);
		end else if (state_q == dhs_pkg::B_CHK) begin
			if (tag_rd == dhs_pkg::TAG_EMPTY) begin
				empty_v_q <= 1'b1;
				slot_q    <= idx_q;
			end else if (tag_rd == dhs_pkg::TAG_FULL && key_rd == key_q) begin
				present_q <= 1'b1;
				slot_q    <= idx_q;
			end else begin
				if (tag_rd == dhs_pkg::TAG_DELETED && !tomb_v_q) begin
					tomb_v_q <= 1'b1;
					tomb_q   <= idx_q;
				end
				idx_q <= idx_nx;
				n_q   <= n_q + CW'(1);
			end
		end
		if (done_go) begin
			out_data.found      <= found_d;
			out_data.changed    <= changed_d;
			out_data.status     <= status_d;
			out_data.live_count <= dhs_pkg::LIVE_W'(used_n - tombs_n);
		end
	end

endmodule

>>> design/double_hash_set_engine.sv
// Hash set of keys in an open-addressed table with double hashing.
// Requests enter on in_valid/in_ready (in_data: req_type, key), results
// leave on out_valid/out_ready (found, changed, status, live_count), one
// result per request, in request order.
// The front takes a request and works out start slot and stride, sixteen
// key bits per step (a quotient phase, then a remainder phase), then
// pushes it to the queue; a clear skips the hash. A two-entry queue feeds
// the back, which probes one slot at a time (a read state, then a check
// state) through the registered tag and key memories, then commits.
// The front takes no new request until it has pushed the last one. Clear
// of a non-empty set sweeps the tag memory.
// After reset the back sweeps the tag memory, with in_ready low;
// load_limit resets to TABLE_SIZE*6/10 and may be written by
// cfg_we/cfg_wdata at any time the block is idle.
// A stalled receiver holds the result register; the back then waits, the
// queue fills and in_ready falls.
module double_hash_set_engine #(
	parameter int TABLE_SIZE = dhs_pkg::TABLE_SIZE_DEF,
	parameter int KEY_WIDTH  = dhs_pkg::KEY_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  dhs_pkg::in_req_t            in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output dhs_pkg::out_rsp_t           out_data,
	input  logic                        cfg_we,
	input  logic [dhs_pkg::LIMIT_W-1:0] cfg_wdata
);

	localparam int IW = $clog2(TABLE_SIZE);
	localparam int QW = 2 + KEY_WIDTH + 2 * IW;
	localparam logic [dhs_pkg::LIMIT_W-1:0] LIMIT_RST = dhs_pkg::LIMIT_W'(
		(TABLE_SIZE * dhs_pkg::LOAD_NUM / dhs_pkg::LOAD_DEN) % (1 << dhs_pkg::LIMIT_W));

	logic [dhs_pkg::LIMIT_W-1:0] load_limit_q;
	dhs_pkg::back_stat_t         stat;
	logic                        f_valid, f_ready, q_valid, q_ready;
	logic [1:0]                  f_req, q_req;
	logic [KEY_WIDTH-1:0]        f_key, q_key;
	logic [IW-1:0]               f_idx, f_stride, q_idx, q_stride;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			load_limit_q <= cfg_wdata;
		end
	end

	dhs_front #(.TABLE_SIZE(TABLE_SIZE), .KEY_WIDTH(KEY_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .stat(stat),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.push_valid(f_valid), .push_ready(f_ready), .push_req(f_req),
		.push_key(f_key), .push_idx(f_idx), .push_stride(f_stride)
	);

	dhs_queue #(.WIDTH(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready),
		.push_data({f_req, f_key, f_idx, f_stride}),
		.pop_valid(q_valid), .pop_ready(q_ready),
		.pop_data({q_req, q_key, q_idx, q_stride})
	);

	dhs_back #(.TABLE_SIZE(TABLE_SIZE), .KEY_WIDTH(KEY_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .load_limit(load_limit_q), .stat(stat),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_req(q_req),
		.pop_key(q_key), .pop_idx(q_idx), .pop_stride(q_stride),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

>>> design/dhs_checker.sv
`include "double_hash_set_engine_macros.svh"

module dhs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input dhs_pkg::out_rsp_t out_data
);

	`DHS_ASSERT_RST(a_rst_quiet, !arst_n |-> !out_valid, "result valid in reset")
	`DHS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result moved")
	`DHS_ASSERT(a_refuse_nochg, out_valid && out_data.status |-> !out_data.changed, "refused request changed set")
	`DHS_ASSERT(a_refuse_absent, out_valid && out_data.status |-> !out_data.found, "refused insert of present key")

endmodule

bind double_hash_set_engine dhs_checker u_dhs_checker (.*);

>>> tb/tb.sv
module tb;

	localparam int SLOTS = 1021;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	dhs_pkg::in_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	dhs_pkg::out_rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [dhs_pkg::LIMIT_W-1:0] cfg_wdata = '0;

	double_hash_set_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow table
	logic [31:0] shadow_keys [SLOTS];
	logic [1:0] shadow_tags [SLOTS];
	int unsigned shadow_used, shadow_tombs;
	logic [dhs_pkg::LIMIT_W-1:0] shadow_limit;
	dhs_pkg::out_rsp_t pending_rsp [$];
	int errors = 0;
	int sent = 0, rsp_seen = 0, refused = 0, reused = 0;
	int stall_cycles = 0;
	logic [31:0] key_pool [$];

	function automatic dhs_pkg::out_rsp_t predict_set(input dhs_pkg::in_req_t r);
		dhs_pkg::out_rsp_t o;
		int unsigned idx, stride, n, live;
		int hit, tomb, empty;
		logic [31:0] k;
		o = '0;
		k = r.key;
		hit = -1; tomb = -1; empty = -1;
		if (dhs_pkg::req_t'(r.req_type) == dhs_pkg::REQ_CLEAR) begin
			if (shadow_used - shadow_tombs != 0) begin
				foreach (shadow_tags[i]) shadow_tags[i] = dhs_pkg::TAG_EMPTY;
				shadow_used = 0;
				shadow_tombs = 0;
				o.changed = 1'b1;
			end
		end else begin
			idx = k % SLOTS;
			stride = 1 + k % (SLOTS - 2);
			for (n = 0; n < SLOTS; n++) begin
				if (shadow_tags[idx] == dhs_pkg::TAG_EMPTY) begin
					empty = idx;
					break;
				end
				if (shadow_tags[idx] == dhs_pkg::TAG_DELETED) begin
					if (tomb < 0) tomb = idx;
				end else if (shadow_keys[idx] == k) begin
					hit = idx;
					break;
				end
				idx = (idx + stride) % SLOTS;
			end
			o.found = hit >= 0;
			if (dhs_pkg::req_t'(r.req_type) == dhs_pkg::REQ_INSERT && hit < 0) begin
				if (tomb >= 0) begin
					shadow_tags[tomb] = dhs_pkg::TAG_FULL;
					shadow_keys[tomb] = k;
					shadow_tombs--;
					o.changed = 1'b1;
					reused++;
				end else if (empty < 0 || shadow_used + 1 > shadow_limit) begin
					o.status = 1'b1;
					refused++;
				end else begin
					shadow_tags[empty] = dhs_pkg::TAG_FULL;
					shadow_keys[empty] = k;
					shadow_used++;
					o.changed = 1'b1;
				end
			end else if (dhs_pkg::req_t'(r.req_type) == dhs_pkg::REQ_REMOVE && hit >= 0) begin
				shadow_tags[hit] = dhs_pkg::TAG_DELETED;
				shadow_tombs++;
				o.changed = 1'b1;
			end
		end
		live = shadow_used - shadow_tombs;
		o.live_count = live[dhs_pkg::LIVE_W-1:0];
		return o;
	endfunction

	function automatic int short_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	int gap_mode = 1;

	task automatic send_req(input dhs_pkg::req_t t, input logic [31:0] k);
		dhs_pkg::in_req_t r;
		int g;
		r.req_type = t;
		r.key = k;
		g = gap_mode ? short_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pending_rsp.push_back(predict_set(r));
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * SLOTS + 50) @(posedge clk);
	endtask

	task automatic set_limit(input logic [dhs_pkg::LIMIT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_limit = v;
	endtask

	function automatic logic [31:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return $urandom();
	endfunction

	// result side: random stalls, or a long hold-off on request
	int hold_off = 0;
	always @(posedge clk) begin
		int g;
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (stall_cycles > 0) begin
			out_ready <= 1'b0;
			stall_cycles <= stall_cycles - 1;
		end else if (gap_mode && $urandom_range(0, 3) == 0) begin
			g = short_gap();
			out_ready <= 1'b0;
			stall_cycles <= g;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		dhs_pkg::out_rsp_t e;
		if (arst_n && out_valid && out_ready) begin
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %p", $time, out_data);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (out_data !== e) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_req(dhs_pkg::REQ_LOOKUP, 32'h0);
		send_req(dhs_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
		send_req(dhs_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
		send_req(dhs_pkg::REQ_INSERT, 32'h0);
		send_req(dhs_pkg::REQ_INSERT, 32'hFFFF_FFFF);
		send_req(dhs_pkg::REQ_INSERT, 32'hFFFF_FFFF);
		send_req(dhs_pkg::REQ_INSERT, SLOTS);
		send_req(dhs_pkg::REQ_INSERT, 2 * SLOTS);
		send_req(dhs_pkg::REQ_LOOKUP, 2 * SLOTS);
		send_req(dhs_pkg::REQ_REMOVE, SLOTS);
		send_req(dhs_pkg::REQ_LOOKUP, 2 * SLOTS);
		send_req(dhs_pkg::REQ_INSERT, 3 * SLOTS);
		send_req(dhs_pkg::REQ_REMOVE, 32'hAAAA_5555);
		send_req(dhs_pkg::REQ_INSERT, 32'h5555_AAAA);
		send_req(dhs_pkg::REQ_CLEAR, 32'h0);
		send_req(dhs_pkg::REQ_CLEAR, 32'h0);
		send_req(dhs_pkg::REQ_INSERT, 32'h1234);
		send_req(dhs_pkg::REQ_REMOVE, 32'h1234);
		send_req(dhs_pkg::REQ_CLEAR, 32'h0);
		send_req(dhs_pkg::REQ_LOOKUP, 32'h1234);
	endtask

	task automatic test_load_limit();
		set_limit(10'd1);
		send_req(dhs_pkg::REQ_CLEAR, 0);
		send_req(dhs_pkg::REQ_INSERT, 32'h7);
		send_req(dhs_pkg::REQ_INSERT, 32'h8);
		send_req(dhs_pkg::REQ_REMOVE, 32'h7);
		send_req(dhs_pkg::REQ_INSERT, 32'h8);
		send_req(dhs_pkg::REQ_INSERT, 32'h9);
		set_limit(10'd8);
		for (int i = 0; i < 30; i++)
			send_req(dhs_pkg::req_t'($urandom_range(0, 2)), $urandom_range(0, 40));
		send_req(dhs_pkg::REQ_CLEAR, 0);
		set_limit(10'd1020);
	endtask

	task automatic test_random(input int count, input int span);
		dhs_pkg::req_t t;
		logic [31:0] k;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 99)) inside
				[0:44]: t = dhs_pkg::REQ_INSERT;
				[45:69]: t = dhs_pkg::REQ_LOOKUP;
				[70:98]: t = dhs_pkg::REQ_REMOVE;
				default: t = dhs_pkg::REQ_CLEAR;
			endcase
			k = span ? $urandom_range(0, span) : pick_key();
			if (key_pool.size() < 400) key_pool.push_back(k);
			send_req(t, k);
		end
	endtask

	task automatic test_backpressure();
		hold_off <= 400;
		gap_mode = 0;
		test_random(40, 0);
		gap_mode = 1;
		drain();
		test_random(20, 0);
	endtask

	task automatic test_fill_to_limit();
		set_limit(10'd1020);
		send_req(dhs_pkg::REQ_CLEAR, 0);
		gap_mode = 0;
		for (int i = 0; i < 300; i++) send_req(dhs_pkg::REQ_INSERT, $urandom());
		gap_mode = 1;
		set_limit(10'd200);
		test_random(60, 0);
		send_req(dhs_pkg::REQ_CLEAR, 0);
	endtask

	initial begin
		foreach (shadow_tags[i]) shadow_tags[i] = dhs_pkg::TAG_EMPTY;
		shadow_used = 0;
		shadow_tombs = 0;
		shadow_limit = 10'(SLOTS * dhs_pkg::LOAD_NUM / dhs_pkg::LOAD_DEN);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_load_limit();
		set_limit(10'd612);
		test_random(400, 0);
		test_backpressure();
		test_random(200, 63);
		test_fill_to_limit();
		set_limit(10'd612);
		test_random(150, 0);
		drain();
		$display("requests %0d, results %0d, refused inserts %0d, tombstone reuses %0d",
			sent, rsp_seen, refused, reused);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("tb failed");
		$finish;
	end
endmodule

>>> files.f
+incdir+design
design/dhs_pkg.sv
design/dhs_ram.sv
design/dhs_queue.sv
design/dhs_front.sv
design/dhs_back.sv
design/double_hash_set_engine.sv
design/dhs_checker.sv
tb/tb.sv
